// File: rtl/core/bcc_pkg.sv
// ---------------------------------------------------------------------------
// bcc_pkg
// shared types and constants of the balance cascade controller: datapath
// widths, loop constants, sequencer states and register indexes
// ---------------------------------------------------------------------------
package bcc_pkg;

    // shared multiplier and accumulator widths
    localparam int OPA_W  = 32;
    localparam int OPB_W  = 25;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int ACC_W  = PROD_W + 1;

    // field and state widths
    localparam int DATA_W     = 16;
    localparam int TGT_W      = 6;
    localparam int TURN_W     = 7;
    localparam int FILT_W     = 18;
    localparam int INTEG_W    = 16;
    localparam int NUM_W      = 22;
    localparam int MAG_W      = 21;
    localparam int Q_W        = 18;
    localparam int DIFF_W     = OPB_W;
    localparam int LIM_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int ANGLE_FRAC_BITS = 8;

    // loop constants
    localparam int SPEED_LIM  = 20;
    localparam int TURN_STEP  = 30;
    localparam int TURN_LIM   = 40;
    localparam int NEAR_DIST  = 20;
    localparam int INTEG_LIM  = 20000;
    localparam int VEL_SAT    = 32767;
    localparam int FILT_NEW   = 3;
    localparam int FILT_OLD   = 7;
    localparam int FILT_DIV   = 10;

    // reciprocal of the filter divisor, quotient estimate low by at most one
    localparam int DIV_SHIFT = 24;
    localparam logic signed [OPA_W-1:0] DIV_RECIP =
        OPA_W'((64'd1 << DIV_SHIFT) / 64'd10);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UPRIGHT_KP    = 3'd0,
        CFG_UPRIGHT_KD    = 3'd1,
        CFG_SPEED_KP      = 3'd2,
        CFG_SPEED_KI      = 3'd3,
        CFG_STEER_KP      = 3'd4,
        CFG_STEER_KD      = 3'd5,
        CFG_BALANCE_ANGLE = 3'd6,
        CFG_DRIVE_LIMIT   = 3'd7
    } t_cfg_idx;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ERR,
        ST_ABS,
        ST_QMUL,
        ST_QEST,
        ST_QFIX,
        ST_FILT,
        ST_INTEG,
        ST_V1,
        ST_V2,
        ST_VTRN,
        ST_VSAT,
        ST_DIFF,
        ST_U1,
        ST_U2,
        ST_UTRN,
        ST_T1,
        ST_T2,
        ST_TTRN,
        ST_MIX,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_TRUNC_G,
        ACC_TRUNC_U
    } t_acc_op;

    typedef struct packed {
        logic    mul_en;
        t_acc_op acc_op;
    } t_mac_ctrl;

    typedef struct packed {
        t_state    state;
        t_mac_ctrl mac;
    } t_seq_out;

endpackage

// File: rtl/core/bcc_mac.sv
// ---------------------------------------------------------------------------
// bcc_mac
// shared signed multiplier with registered product, and an accumulator that
// loads, adds or truncates toward zero by the gain or gain plus angle shift
// ---------------------------------------------------------------------------
module bcc_mac
    import bcc_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  t_mac_ctrl                i_ctrl,
    input  logic signed [OPA_W-1:0]  i_op_a,
    input  logic signed [OPB_W-1:0]  i_op_b,
    output logic signed [PROD_W-1:0] o_prod,
    output logic signed [ACC_W-1:0]  o_acc
);

    localparam int SH_G = GAIN_FRAC_BITS;
    localparam int SH_U = GAIN_FRAC_BITS + ANGLE_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] BIAS_G = {{(ACC_W-SH_G){1'b0}}, {SH_G{1'b1}}};
    localparam logic signed [ACC_W-1:0] BIAS_U = {{(ACC_W-SH_U){1'b0}}, {SH_U{1'b1}}};

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  w_prod_ext;
    logic signed [ACC_W-1:0]  w_sum;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= i_op_a * i_op_b;
        end
        r_acc <= n_acc;
    end

    always_comb begin
        w_prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        w_sum      = '0;
        n_acc      = r_acc;
        case (i_ctrl.acc_op)
            ACC_HOLD: begin
                n_acc = r_acc;
            end
            ACC_LOAD: begin
                n_acc = w_prod_ext;
            end
            ACC_ADD: begin
                n_acc = r_acc + w_prod_ext;
            end
            ACC_TRUNC_G: begin
                // negative values get a bias so the shift rounds toward zero
                w_sum = r_acc + (r_acc[ACC_W-1] ? BIAS_G : '0);
                n_acc = w_sum >>> SH_G;
            end
            ACC_TRUNC_U: begin
                w_sum = r_acc + (r_acc[ACC_W-1] ? BIAS_U : '0);
                n_acc = w_sum >>> SH_U;
            end
            default: begin
                n_acc = r_acc;
            end
        endcase
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

// File: rtl/core/bcc_seq.sv
// ---------------------------------------------------------------------------
// bcc_seq
// control tick sequencer: steps one item through the filter, the divide by
// reciprocal and the three gain stages, driving the shared multiply unit
// ---------------------------------------------------------------------------
module bcc_seq
    import bcc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_out_free,
    output t_seq_out o_seq
);

    t_state    r_state;
    t_state    n_state;
    t_mac_ctrl w_mac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        w_mac.mul_en  = 1'b0;
        w_mac.acc_op  = ACC_HOLD;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_ERR;
                end
            end
            ST_ERR:  n_state = ST_ABS;
            ST_ABS:  n_state = ST_QMUL;
            ST_QMUL: begin
                w_mac.mul_en = 1'b1;
                n_state      = ST_QEST;
            end
            ST_QEST: n_state = ST_QFIX;
            ST_QFIX: n_state = ST_FILT;
            ST_FILT: n_state = ST_INTEG;
            ST_INTEG: begin
                w_mac.mul_en = 1'b1;
                n_state      = ST_V1;
            end
            ST_V1: begin
                w_mac.mul_en = 1'b1;
                w_mac.acc_op = ACC_LOAD;
                n_state      = ST_V2;
            end
            ST_V2: begin
                w_mac.acc_op = ACC_ADD;
                n_state      = ST_VTRN;
            end
            ST_VTRN: begin
                w_mac.acc_op = ACC_TRUNC_G;
                n_state      = ST_VSAT;
            end
            ST_VSAT: n_state = ST_DIFF;
            ST_DIFF: begin
                w_mac.mul_en = 1'b1;
                n_state      = ST_U1;
            end
            ST_U1: begin
                w_mac.mul_en = 1'b1;
                w_mac.acc_op = ACC_LOAD;
                n_state      = ST_U2;
            end
            ST_U2: begin
                w_mac.acc_op = ACC_ADD;
                n_state      = ST_UTRN;
            end
            ST_UTRN: begin
                w_mac.mul_en = 1'b1;
                w_mac.acc_op = ACC_TRUNC_U;
                n_state      = ST_T1;
            end
            ST_T1: begin
                w_mac.mul_en = 1'b1;
                w_mac.acc_op = ACC_LOAD;
                n_state      = ST_T2;
            end
            ST_T2: begin
                w_mac.acc_op = ACC_ADD;
                n_state      = ST_TTRN;
            end
            ST_TTRN: begin
                w_mac.acc_op = ACC_TRUNC_G;
                n_state      = ST_MIX;
            end
            ST_MIX: n_state = ST_DONE;
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_seq.state = r_state;
    assign o_seq.mac   = w_mac;

endmodule

// File: rtl/core/balance_robot_cascade_control_top.sv
// ---------------------------------------------------------------------------
// balance_robot_cascade_control_top
// two-wheel balance cascade controller: speed and turn ramps, filtered
// velocity PI, upright PD about the shifted balance angle, turn PD, mixing
// and symmetric saturation of the two motor drives
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ------------------------------
//  sensor    in         i_valid / o_ready      encoders, pitch, gyros, buttons,
//                                              distance, clear_integral
//  drive     out        o_valid / i_ready      o_motor_left, o_motor_right
//  config    in         i_cfg_wr_en (no wait)  i_cfg_index, i_cfg_data
//
//  from its transfer until o_ready rises again, one item keeps the sequencer
//  walking one shared 32x25 multiplier and one accumulator through the
//  divide by ten and six gain products
//  the drive pair enters the output register, and o_valid rises, on the same
//  edge that returns the sequencer to idle
//  a pending result does not block the next input transfer; only when a new
//  result is finished while the old one still waits does the sequencer hold
//  reset (synchronous, active low) restores gains and clears loop state
// ---------------------------------------------------------------------------
module balance_robot_cascade_control_top
    import bcc_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // sensor channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [DATA_W-1:0]     i_wheel_cnt_l,
    input  logic signed [DATA_W-1:0]     i_wheel_cnt_r,
    input  logic signed [DATA_W-1:0]     i_pitch,
    input  logic signed [DATA_W-1:0]     i_gyro_y,
    input  logic signed [DATA_W-1:0]     i_gyro_z,
    input  logic                         i_forward,
    input  logic                         i_backward,
    input  logic                         i_steer_left,
    input  logic                         i_steer_right,
    input  logic        [DATA_W-1:0]     i_distance,
    input  logic                         i_clear_integral,
    // drive channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DATA_W-1:0]     o_motor_left,
    output logic signed [DATA_W-1:0]     o_motor_right,
    // configuration writes
    input  logic                         i_cfg_wr_en,
    input  logic        [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [CFG_DATA_W-1:0] i_cfg_data
);

    // stage results after the gain shift, and their mixed sums
    localparam int STG_W = ACC_W - GAIN_FRAC_BITS;
    localparam int SUM_W = STG_W + 1;

    // configuration registers
    logic signed [OPA_W-1:0]  r_upright_kp;
    logic signed [OPA_W-1:0]  r_upright_kd;
    logic signed [OPA_W-1:0]  r_speed_kp;
    logic signed [OPA_W-1:0]  r_speed_ki;
    logic signed [OPA_W-1:0]  r_steer_kp;
    logic signed [OPA_W-1:0]  r_steer_kd;
    logic signed [DATA_W-1:0] r_balance_angle;
    logic        [LIM_W-1:0]  r_drive_limit;

    // loop state kept from tick to tick
    logic signed [TGT_W-1:0]   r_speed_target;
    logic signed [TURN_W-1:0]  r_turn_cmd;
    logic signed [FILT_W-1:0]  r_filt_err;
    logic signed [INTEG_W-1:0] r_err_integ;

    // captured item
    logic signed [DATA_W-1:0] r_enc_l;
    logic signed [DATA_W-1:0] r_enc_r;
    logic signed [DATA_W-1:0] r_pitch;
    logic signed [DATA_W-1:0] r_gyro_y;
    logic signed [DATA_W-1:0] r_gyro_z;
    logic                     r_clear;
    logic                     r_steer_idle;

    // working registers
    logic signed [NUM_W-1:0]  r_num;
    logic                     r_neg;
    logic        [MAG_W-1:0]  r_mag;
    logic        [Q_W-1:0]    r_q;
    logic signed [DATA_W-1:0] r_vel;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [STG_W-1:0]  r_upright;
    logic signed [SUM_W-1:0]  r_sum_l;
    logic signed [SUM_W-1:0]  r_sum_r;

    // output register
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_motor_l;
    logic signed [DATA_W-1:0] r_motor_r;

    logic                     w_accept;
    logic                     w_out_free;
    t_seq_out                 w_seq;
    logic signed [OPA_W-1:0]  w_op_a;
    logic signed [OPB_W-1:0]  w_op_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  w_acc;

    logic signed [TGT_W+1:0]  w_tgt;
    logic signed [TURN_W:0]   w_turn;
    logic signed [FILT_W-1:0] w_err;
    logic signed [NUM_W-1:0]  w_num;
    logic        [NUM_W-1:0]  w_abs;
    logic        [MAG_W-1:0]  w_rem;
    logic signed [INTEG_W+2:0] w_isum;
    logic signed [INTEG_W-1:0] w_integ;
    logic signed [STG_W-1:0]  w_turn_out;
    logic signed [SUM_W-1:0]  w_lim;

    function automatic logic signed [DATA_W-1:0] sat_drive(
        input logic signed [SUM_W-1:0] sum,
        input logic signed [SUM_W-1:0] lim
    );
        logic signed [SUM_W-1:0] res;
        res = sum;
        if (sum > lim) begin
            res = lim;
        end else if (sum < -lim) begin
            res = -lim;
        end
        return res[DATA_W-1:0];
    endfunction

    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign o_ready    = (w_seq.state == ST_IDLE);

    bcc_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_out_free (w_out_free),
        .o_seq      (w_seq)
    );

    bcc_mac #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_mac (
        .i_clk  (i_clk),
        .i_ctrl (w_seq.mac),
        .i_op_a (w_op_a),
        .i_op_b (w_op_b),
        .o_prod (w_prod),
        .o_acc  (w_acc)
    );

    // operand selection for the shared multiplier
    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        case (w_seq.state)
            ST_QMUL: begin
                // magnitude of the filter numerator times the reciprocal of ten
                w_op_a = DIV_RECIP;
                w_op_b = OPB_W'($signed({1'b0, r_mag}));
            end
            ST_INTEG: begin
                w_op_a = r_speed_kp;
                w_op_b = OPB_W'(r_filt_err);
            end
            ST_V1: begin
                w_op_a = r_speed_ki;
                w_op_b = OPB_W'(r_err_integ);
            end
            ST_DIFF: begin
                // gyro rate lifted to the Q8.8 angle scale
                w_op_a = r_upright_kd;
                w_op_b = OPB_W'(r_gyro_y) <<< ANGLE_FRAC_BITS;
            end
            ST_U1: begin
                w_op_a = r_upright_kp;
                w_op_b = r_diff;
            end
            ST_UTRN: begin
                // derivative turn gain only while no steering button is held
                w_op_a = r_steer_idle ? r_steer_kd : '0;
                w_op_b = OPB_W'(r_gyro_z);
            end
            ST_T1: begin
                w_op_a = r_steer_kp;
                w_op_b = OPB_W'(r_turn_cmd);
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    // speed and turn ramps, from the buttons at the transfer
    always_comb begin
        w_tgt = (i_forward || i_backward) ? (TGT_W+2)'(r_speed_target) : '0;
        if (i_forward) begin
            // near obstacle turns the forward ramp around
            w_tgt = (i_distance < NEAR_DIST) ? w_tgt + (TGT_W+2)'(1)
                                             : w_tgt - (TGT_W+2)'(1);
        end
        if (i_backward) begin
            w_tgt = w_tgt + (TGT_W+2)'(1);
        end
        if (w_tgt > SPEED_LIM) begin
            w_tgt = (TGT_W+2)'(SPEED_LIM);
        end else if (w_tgt < -SPEED_LIM) begin
            w_tgt = (TGT_W+2)'(-SPEED_LIM);
        end

        w_turn = (i_steer_left || i_steer_right) ? (TURN_W+1)'(r_turn_cmd) : '0;
        if (i_steer_left) begin
            w_turn = w_turn + (TURN_W+1)'(TURN_STEP);
        end
        if (i_steer_right) begin
            w_turn = w_turn - (TURN_W+1)'(TURN_STEP);
        end
        if (w_turn > TURN_LIM) begin
            w_turn = (TURN_W+1)'(TURN_LIM);
        end else if (w_turn < -TURN_LIM) begin
            w_turn = (TURN_W+1)'(-TURN_LIM);
        end
    end

    // velocity error, filter numerator, quotient fix-up and integrator
    always_comb begin
        w_err = FILT_W'(r_enc_l) + FILT_W'(r_enc_r) - FILT_W'(r_speed_target);
        w_num = NUM_W'(NUM_W'(w_err) * FILT_NEW + NUM_W'(r_filt_err) * FILT_OLD);
        w_abs = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);
        // estimate is never above the true quotient, so one step corrects it
        w_rem = r_mag - MAG_W'(MAG_W'(r_q) * FILT_DIV);

        w_isum = (INTEG_W+3)'(r_err_integ) + (INTEG_W+3)'(r_filt_err);
        if (w_isum > INTEG_LIM) begin
            w_integ = INTEG_W'(INTEG_LIM);
        end else if (w_isum < -INTEG_LIM) begin
            w_integ = INTEG_W'(-INTEG_LIM);
        end else begin
            w_integ = w_isum[INTEG_W-1:0];
        end
        if (r_clear) begin
            w_integ = '0;
        end

        w_turn_out = $signed(w_acc[STG_W-1:0]);
        w_lim      = SUM_W'($signed({1'b0, r_drive_limit}));
    end

    // configuration and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upright_kp    <= 32'sd23592960;
            r_upright_kd    <= 32'sd131072;
            r_speed_kp      <= -32'sd26214;
            r_speed_ki      <= -32'sd131;
            r_steer_kp      <= -32'sd1310720;
            r_steer_kd      <= 32'sd39322;
            r_balance_angle <= 16'sd2048;
            r_drive_limit   <= 15'd7200;
            r_speed_target  <= '0;
            r_turn_cmd      <= '0;
            r_filt_err      <= '0;
            r_err_integ     <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_UPRIGHT_KP:    r_upright_kp    <= $signed(i_cfg_data);
                    CFG_UPRIGHT_KD:    r_upright_kd    <= $signed(i_cfg_data);
                    CFG_SPEED_KP:      r_speed_kp      <= $signed(i_cfg_data);
                    CFG_SPEED_KI:      r_speed_ki      <= $signed(i_cfg_data);
                    CFG_STEER_KP:      r_steer_kp      <= $signed(i_cfg_data);
                    CFG_STEER_KD:      r_steer_kd      <= $signed(i_cfg_data);
                    CFG_BALANCE_ANGLE: r_balance_angle <= $signed(i_cfg_data[DATA_W-1:0]);
                    CFG_DRIVE_LIMIT:   r_drive_limit   <= i_cfg_data[LIM_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (w_accept) begin
                r_speed_target <= w_tgt[TGT_W-1:0];
                r_turn_cmd     <= w_turn[TURN_W-1:0];
            end

            if (w_seq.state == ST_FILT) begin
                r_filt_err <= r_neg ? -$signed(r_q) : $signed(r_q);
            end

            if (w_seq.state == ST_INTEG) begin
                r_err_integ <= w_integ;
            end

            // result waits here; the next item may already be in flight
            if (w_seq.state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item capture and working registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_enc_l      <= i_wheel_cnt_l;
            r_enc_r      <= i_wheel_cnt_r;
            r_pitch      <= i_pitch;
            r_gyro_y     <= i_gyro_y;
            r_gyro_z     <= i_gyro_z;
            r_clear      <= i_clear_integral;
            r_steer_idle <= !i_steer_left && !i_steer_right;
        end
        case (w_seq.state)
            ST_ERR: begin
                r_num <= w_num;
            end
            ST_ABS: begin
                r_neg <= r_num[NUM_W-1];
                r_mag <= w_abs[MAG_W-1:0];
            end
            ST_QEST: begin
                r_q <= w_prod[DIV_SHIFT +: Q_W];
            end
            ST_QFIX: begin
                if (w_rem >= FILT_DIV) begin
                    r_q <= r_q + 1'b1;
                end
            end
            ST_VSAT: begin
                // velocity output saturates before it shifts the balance angle
                if (w_acc > VEL_SAT) begin
                    r_vel <= DATA_W'(VEL_SAT);
                end else if (w_acc < -VEL_SAT) begin
                    r_vel <= DATA_W'(-VEL_SAT);
                end else begin
                    r_vel <= w_acc[DATA_W-1:0];
                end
            end
            ST_DIFF: begin
                r_diff <= DIFF_W'(r_pitch) - DIFF_W'(r_balance_angle)
                          - (DIFF_W'(r_vel) <<< ANGLE_FRAC_BITS);
            end
            ST_T1: begin
                r_upright <= $signed(w_acc[STG_W-1:0]);
            end
            ST_MIX: begin
                r_sum_l <= SUM_W'(r_upright) - SUM_W'(w_turn_out);
                r_sum_r <= SUM_W'(r_upright) + SUM_W'(w_turn_out);
            end
            default: begin
            end
        endcase
        if (w_seq.state == ST_DONE && w_out_free) begin
            r_motor_l <= sat_drive(r_sum_l, w_lim);
            r_motor_r <= sat_drive(r_sum_r, w_lim);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_motor_left  = r_motor_l;
    assign o_motor_right = r_motor_r;

    // integrator never leaves its clamp
    a_integ_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err_integ <= INTEG_LIM) && (r_err_integ >= -INTEG_LIM))
        else $error("velocity integrator outside its clamp");

    // ramps stay inside their limits
    a_ramp_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_speed_target <= SPEED_LIM) && (r_speed_target >= -SPEED_LIM)
        && (r_turn_cmd <= TURN_LIM) && (r_turn_cmd >= -TURN_LIM))
        else $error("speed target or turn command outside its limit");

    // a transfer starts the sequence and drops ready
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (w_seq.state == ST_ERR) && !o_ready)
        else $error("sequencer did not start on input transfer");

    // a finished result reaches the output register and frees the sequencer
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_seq.state == ST_DONE && w_out_free) |=> (o_valid && o_ready))
        else $error("finished result not loaded into output register");

    // a held result stalls the sequencer in its last step
    a_done_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_seq.state == ST_DONE && !w_out_free) |=> (w_seq.state == ST_DONE))
        else $error("result overwritten while output still waiting");

endmodule
